// File: rtl/tch_pkg.sv
// ---------------------------------------------------------------------------
// tch_pkg: shared types and constants of the Taylor cosine unit
// Fixed-point formats and the Q5.26 coefficient table (-1)^(k/2)/k!.
// ---------------------------------------------------------------------------
package tch_pkg;

    localparam int AngleWidth  = 16;   // Q2.13
    localparam int AccWidth    = 32;   // Q5.26
    localparam int DegWidth    = 5;
    localparam int FracX       = 13;
    localparam int ProdWidth   = AccWidth + AngleWidth;
    localparam int TableTop    = 24;

    localparam logic [DegWidth-1:0] DegreeReset = 5'd8;

    typedef logic signed [AngleWidth-1:0] angle_t;
    typedef logic signed [AccWidth-1:0]   acc_t;
    typedef logic signed [ProdWidth-1:0]  prod_t;
    typedef logic [DegWidth-1:0]          degree_t;

    // Coefficients rounded to nearest in Q5.26; odd terms are zero.
    function automatic acc_t tch_coef(input degree_t k);
        acc_t c;
        case (k)
            5'd0:    c = 32'sd67108864;
            5'd2:    c = -32'sd33554432;
            5'd4:    c = 32'sd2796203;
            5'd6:    c = -32'sd93207;
            5'd8:    c = 32'sd1664;
            5'd10:   c = -32'sd18;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/taylor_cosine_horner_unit.sv
// ---------------------------------------------------------------------------
// taylor_cosine_horner_unit: pipelined Taylor-series cosine
// Angle in Q2.13 radians in, saturated Q5.26 polynomial value out.
// ---------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready carry s_x_angle; m_valid/m_ready carry m_cosine. An item
//   transfers on an edge where valid and ready are both high.
//   cfg_wr_en/cfg_wr_data write the polynomial degree (0..31, clamped to
//   MAX_DEGREE); write it only while no transfer is in flight.
//   Each of the MAX_DEGREE Horner steps is a multiply stage followed by a
//   round, add and saturate stage. Throughput is one angle per cycle while
//   the receiver keeps m_ready high.
//   Steps above the configured degree see zero coefficients, so a fixed-depth
//   pipeline serves every degree.
//   Reset (aresetn low, synchronous) empties the pipeline and sets degree 8.
//   When the receiver holds m_ready low, stages fill up behind the output
//   and s_ready drops once every stage holds an item; nothing is dropped.
// ---------------------------------------------------------------------------
module taylor_cosine_horner_unit
    import tch_pkg::*;
#(
    parameter int MAX_DEGREE = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [DegWidth-1:0]   cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [AngleWidth-1:0] s_x_angle,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [AccWidth-1:0]   m_cosine
);

    localparam degree_t MaxDeg = degree_t'(MAX_DEGREE);

    degree_t degree_reg;
    degree_t deg_eff;

    logic   valid [MAX_DEGREE+1];
    logic   ready [MAX_DEGREE+1];
    acc_t   acc   [MAX_DEGREE+1];
    angle_t x     [MAX_DEGREE+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= DegreeReset;
        end else if (cfg_wr_en) begin
            degree_reg <= cfg_wr_data;
        end
    end

    assign deg_eff = (degree_reg > MaxDeg) ? MaxDeg : degree_reg;

    assign valid[0] = s_valid;
    assign s_ready  = ready[0];
    assign acc[0]   = (MaxDeg <= deg_eff) ? tch_coef(MaxDeg) : '0;
    assign x[0]     = s_x_angle;

    for (genvar j = 0; j < MAX_DEGREE; j++) begin : g_step
        localparam degree_t K = degree_t'(MAX_DEGREE - 1 - j);
        acc_t coef;

        assign coef = (K <= deg_eff) ? tch_coef(K) : '0;

        tch_horner_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid[j]),
            .in_ready  (ready[j]),
            .acc_in    (acc[j]),
            .x_in      (x[j]),
            .coef_in   (coef),
            .out_valid (valid[j+1]),
            .out_ready (ready[j+1]),
            .acc_out   (acc[j+1]),
            .x_out     (x[j+1])
        );
    end

    assign m_valid            = valid[MAX_DEGREE];
    assign ready[MAX_DEGREE]  = m_ready;
    assign m_cosine           = acc[MAX_DEGREE];

    // reset loads the default degree
    a_degree_reset: assert property (@(posedge aclk) !aresetn |=> degree_reg == DegreeReset)
        else $error("degree register not at default after reset");

    // a configuration write lands in the degree register
    a_degree_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> degree_reg == $past(cfg_wr_data))
        else $error("degree write lost");

    // backpressure reaches the input only when the output is stalled and full
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while output free");

endmodule

// File: rtl/tch_horner_step.sv
// ---------------------------------------------------------------------------
// tch_horner_step: one Horner step, acc = sat32(round(acc * x / 2^13) + c)
// Two register stages: the multiply, then round, add and saturate.
// ---------------------------------------------------------------------------
module tch_horner_step
    import tch_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  acc_t   acc_in,
    input  angle_t x_in,
    input  acc_t   coef_in,
    output logic   out_valid,
    input  logic   out_ready,
    output acc_t   acc_out,
    output angle_t x_out
);

    localparam logic signed [AccWidth+3:0] SatMax = 36'sd2147483647;
    localparam logic signed [AccWidth+3:0] SatMin = -36'sd2147483648;
    localparam prod_t RoundBias = prod_t'(1) <<< (FracX - 1);

    logic   mul_valid_reg;
    prod_t  prod_reg;
    prod_t  prod_next;
    angle_t mul_x_reg;
    logic   mul_en;

    logic   add_valid_reg;
    acc_t   acc_reg;
    acc_t   acc_next;
    angle_t add_x_reg;
    logic   add_en;

    prod_t                      rounded;
    logic signed [AccWidth+3:0] sum;

    assign add_en   = !add_valid_reg || out_ready;
    assign mul_en   = !mul_valid_reg || add_en;
    assign in_ready = mul_en;

    assign prod_next = acc_in * x_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (mul_en) begin
            mul_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_en && in_valid) begin
            prod_reg  <= prod_next;
            mul_x_reg <= x_in;
        end
    end

    // round half up, floor shift, then add the coefficient and clamp
    always_comb begin
        rounded = (prod_reg + RoundBias) >>> FracX;
        sum     = (AccWidth+4)'(rounded)
                + (AccWidth+4)'(coef_in);
        if (sum > SatMax) begin
            acc_next = acc_t'(SatMax);
        end else if (sum < SatMin) begin
            acc_next = acc_t'(SatMin);
        end else begin
            acc_next = sum[AccWidth-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            add_valid_reg <= 1'b0;
        end else if (add_en) begin
            add_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (add_en && mul_valid_reg) begin
            acc_reg   <= acc_next;
            add_x_reg <= mul_x_reg;
        end
    end

    assign out_valid = add_valid_reg;
    assign acc_out   = acc_reg;
    assign x_out     = add_x_reg;

endmodule
